// File: src/assert_macros.svh
// Assertion macros for the RTL of the descriptor tag verifier.
// Depends on nothing; clock and reset names follow the house convention.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/dtv_pkg.sv
// Package for the descriptor tag verifier: item structs, status codes,
// tag layout constants and the byte-wide CRC-16 update. No dependencies.
`default_nettype none

package dtv_pkg;

    localparam int unsigned TAG_BYTES = 16;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // Byte offsets within the 16-byte tag
    localparam logic [3:0] POS_ID_LO   = 4'd0;
    localparam logic [3:0] POS_ID_HI   = 4'd1;
    localparam logic [3:0] POS_CSUM    = 4'd4;
    localparam logic [3:0] POS_CRC_LO  = 4'd8;
    localparam logic [3:0] POS_CRC_HI  = 4'd9;
    localparam logic [3:0] POS_LEN_LO  = 4'd10;
    localparam logic [3:0] POS_LEN_HI  = 4'd11;
    localparam logic [3:0] POS_LOC_0   = 4'd12;
    localparam logic [3:0] POS_LOC_1   = 4'd13;
    localparam logic [3:0] POS_LOC_2   = 4'd14;
    localparam logic [3:0] POS_LOC_3   = 4'd15;
    localparam logic [3:0] POS_TAG_END = 4'd15;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LOC_ERR   = 2'd1,
        ST_CSUM_ERR  = 2'd2,
        ST_CRC_ERR   = 2'd3
    } t_status;

    typedef struct packed {
        logic        start_of_descriptor;
        logic [7:0]  data_byte;
        logic [31:0] expected_location;
        logic        check_crc;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] computed_crc;
        logic [15:0] tag_identifier;
    } t_out_item;

    // CRC-16, MSB first, one byte: eight shift/xor steps on a 16-bit value
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/descriptor_tag_verifier.sv
// Descriptor tag verifier top level: byte parser, checks and output buffer.
// Depends on dtv_pkg and assert_macros.svh.
// Usage:
//  - Input channel (i_in_valid / i_in_item / o_in_stall) carries one
//    descriptor byte per item; start_of_descriptor marks tag byte 0 and
//    samples expected_location and check_crc.
//  - Output channel (o_out_valid / o_out_item / i_out_stall) gives one item
//    per descriptor: at tag byte 15 on a location or checksum failure, when
//    the CRC is off or its length is zero, otherwise with the last CRC byte.
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes crc_seed;
//    ready is always high, the seed is picked up at the next start byte.
//  - Throughput: one byte per cycle while o_in_stall is low. All work for a
//    byte happens in the accept cycle; the result is registered in the output
//    register, or in the skid entry while that register is held.
//  - Stall: a two-entry output buffer (output register plus skid). Input
//    keeps flowing while one result waits; o_in_stall rises only when the
//    skid entry is occupied, and it is a registered signal.
//  - Reset (synchronous, active low) empties the output buffer, clears the
//    seed to zero and returns the parser to idle; bytes without a start
//    marker are dropped while idle.
`default_nettype none
`include "assert_macros.svh"

module descriptor_tag_verifier
    import dtv_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // byte input
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    output logic           o_in_stall,
    // results
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    input  wire logic      i_out_stall,
    // crc_seed register write
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [16:0] TAG_BYTES_W = 17'(TAG_BYTES);

    // Parser state
    logic        r_active;
    logic [16:0] r_pos;
    logic [7:0]  r_sum;
    logic [15:0] r_crc;
    logic [7:0]  r_csum;
    logic [15:0] r_stored_crc;
    logic [15:0] r_len;
    logic [31:0] r_loc;
    logic [31:0] r_expected;
    logic [15:0] r_ident;
    logic        r_crc_en;
    logic [15:0] r_crc_seed;

    // Output buffer
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        r_skid_valid;
    t_out_item   r_skid_item;

    // Effective state for the current byte (start byte reloads it)
    logic        c_active;
    logic [16:0] c_pos;
    logic [7:0]  c_sum;
    logic [15:0] c_crc;
    logic [7:0]  c_csum;
    logic [15:0] c_stored_crc;
    logic [15:0] c_len;
    logic [31:0] c_loc;
    logic [31:0] c_expected;
    logic [15:0] c_ident;
    logic        c_crc_en;

    logic        n_active;
    logic [16:0] n_pos;
    logic [7:0]  n_sum;
    logic [15:0] n_crc;
    logic [7:0]  n_csum;
    logic [15:0] n_stored_crc;
    logic [15:0] n_len;
    logic [31:0] n_loc;
    logic [15:0] n_ident;

    logic        w_in_acc;
    logic        w_start;
    logic [7:0]  w_byte;
    logic        w_in_tag;
    logic        w_emit;
    t_status     w_status;
    t_out_item   w_result;
    logic        w_out_take;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_start     = i_in_item.start_of_descriptor;
    assign w_byte      = i_in_item.data_byte;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_out_take  = r_out_valid && !i_out_stall;

    // A start byte drops whatever was in progress and reloads the context
    always_comb begin
        if (w_start) begin
            c_active     = 1'b1;
            c_pos        = '0;
            c_sum        = '0;
            c_crc        = r_crc_seed;
            c_csum       = '0;
            c_stored_crc = '0;
            c_len        = '0;
            c_loc        = '0;
            c_expected   = i_in_item.expected_location;
            c_ident      = '0;
            c_crc_en     = i_in_item.check_crc;
        end else begin
            c_active     = r_active;
            c_pos        = r_pos;
            c_sum        = r_sum;
            c_crc        = r_crc;
            c_csum       = r_csum;
            c_stored_crc = r_stored_crc;
            c_len        = r_len;
            c_loc        = r_loc;
            c_expected   = r_expected;
            c_ident      = r_ident;
            c_crc_en     = r_crc_en;
        end
    end

    assign w_in_tag = (c_pos[16:4] == '0);

    // Byte parse, running checksum / CRC and the check ladder
    always_comb begin
        n_active     = c_active;
        n_pos        = c_pos + 17'd1;
        n_sum        = c_sum;
        n_crc        = c_crc;
        n_csum       = c_csum;
        n_stored_crc = c_stored_crc;
        n_len        = c_len;
        n_loc        = c_loc;
        n_ident      = c_ident;
        w_emit       = 1'b0;
        w_status     = ST_OK;

        if (w_in_tag) begin
            if (c_pos[3:0] != POS_CSUM) begin
                n_sum = c_sum + w_byte;
            end
            unique case (c_pos[3:0])
                POS_ID_LO:  n_ident[7:0]       = w_byte;
                POS_ID_HI:  n_ident[15:8]      = w_byte;
                POS_CSUM:   n_csum             = w_byte;
                POS_CRC_LO: n_stored_crc[7:0]  = w_byte;
                POS_CRC_HI: n_stored_crc[15:8] = w_byte;
                POS_LEN_LO: n_len[7:0]         = w_byte;
                POS_LEN_HI: n_len[15:8]        = w_byte;
                POS_LOC_0:  n_loc[7:0]         = w_byte;
                POS_LOC_1:  n_loc[15:8]        = w_byte;
                POS_LOC_2:  n_loc[23:16]       = w_byte;
                POS_LOC_3:  n_loc[31:24]       = w_byte;
                default: ;
            endcase
            if (c_pos[3:0] == POS_TAG_END) begin
                // first failing check wins
                priority if (n_loc != c_expected) begin
                    w_emit   = 1'b1;
                    w_status = ST_LOC_ERR;
                end else if (n_sum != n_csum) begin
                    w_emit   = 1'b1;
                    w_status = ST_CSUM_ERR;
                end else if (!c_crc_en) begin
                    w_emit   = 1'b1;
                    w_status = ST_OK;
                end else if (n_len == '0) begin
                    w_emit   = 1'b1;
                    w_status = (c_crc == n_stored_crc) ? ST_OK : ST_CRC_ERR;
                end else begin
                    w_emit   = 1'b0;
                end
            end
        end else begin
            // body byte under CRC
            n_crc = crc_byte(c_crc, w_byte);
            if (n_pos >= TAG_BYTES_W + {1'b0, c_len}) begin
                w_emit   = 1'b1;
                w_status = (n_crc == c_stored_crc) ? ST_OK : ST_CRC_ERR;
            end
        end

        if (!c_active) begin
            w_emit = 1'b0;
        end
        if (w_emit) begin
            n_active = 1'b0;
        end
    end

    assign w_result.status         = w_status;
    assign w_result.computed_crc   = n_crc;
    assign w_result.tag_identifier = n_ident;

    // Parser registers: only move on an accepted byte that is in a descriptor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_in_acc && c_active) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && c_active) begin
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            r_crc        <= n_crc;
            r_csum       <= n_csum;
            r_stored_crc <= n_stored_crc;
            r_len        <= n_len;
            r_loc        <= n_loc;
            r_expected   <= c_expected;
            r_ident      <= n_ident;
            r_crc_en     <= c_crc_en;
        end
    end

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_seed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_crc_seed <= i_cfg_data;
        end
    end

    // Output register plus skid entry; skid drains first to keep order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_in_acc && w_emit;
                end
            end else if (w_in_acc && w_emit) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (w_in_acc && w_emit) begin
                r_out_item <= w_result;
            end
        end else if (w_in_acc && w_emit) begin
            r_skid_item <= w_result;
        end
    end

    // Checks
    `ASSERT_CLK(a_skid_behind_out, r_skid_valid |-> r_out_valid,
        "skid entry held while output register empty")
    `ASSERT_CLK(a_emit_ends_desc, (w_in_acc && w_emit) |=> !r_active,
        "descriptor still active after its result")
    `ASSERT_CLK(a_idle_no_result, (w_in_acc && !w_start && !r_active) |-> !w_emit,
        "result from a byte outside any descriptor")
    `ASSERT_CLK(a_body_needs_crc, (r_active && (r_pos[16:4] != '0)) |-> r_crc_en,
        "body bytes consumed without CRC enabled")
    `ASSERT_CLK(a_no_drop, (r_skid_valid && i_out_stall && r_out_valid) |=> r_skid_valid,
        "skid entry lost while output stalled")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for descriptor_tag_verifier: byte-wide descriptor stream in,
// one verdict per descriptor out, checked against a local tag/CRC-16 predictor.
// Depends on dtv_pkg and the descriptor_tag_verifier RTL only.

module tb;
    import dtv_pkg::*;

    localparam int STUCK_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 400;   // one long receiver hold-off
    localparam int SETTLE_CYCLES = 4;     // idle wait before a seed write and at the end
    localparam int PHASE_BYTES   = 150;

    // one descriptor to be sent
    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] loc;        // location written into the tag
        logic [31:0] want;       // expected_location given with the start byte
        logic        sum_bad;    // corrupt the checksum byte
        logic        crc_on;
        logic [15:0] len;        // CRC length field and body bytes sent
        logic        crc_ok;     // tag carries the true body CRC
        logic [15:0] crc_field;  // tag CRC when crc_ok is clear
        int          cut;        // bytes sent before a restart, 0 = all
        int          tail;       // stray non-start bytes afterwards
        logic        seed_mid;   // rewrite the seed halfway through the body
        logic        typed;      // verdict given below, not predicted
        t_status     st;
        logic [15:0] crc;
    } t_desc;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [15:0] cfg_data = '0;

    logic calm     = 1'b0;   // no idling on either side
    logic hold_req = 1'b0;   // ask the receiver for its long hold-off

    t_out_item verdicts [$];
    t_desc     plan [$];
    int        fails        = 0;
    int        bytes_sent   = 0;
    int        quiet_cycles = 0;
    int        hold_left    = 0;
    bit        hold_used    = 1'b0;

    // predictor state
    logic [15:0] seed      = '0;
    logic [16:0] parse_pos = '0;
    logic [7:0]  tag_sum   = '0;
    logic [15:0] body_crc  = '0;
    logic [7:0]  tag_csum  = '0;
    logic [15:0] tag_crc   = '0;
    logic [15:0] crc_len   = '0;
    logic [31:0] tag_loc   = '0;
    logic [31:0] want_loc  = '0;
    logic [15:0] tag_ident = '0;
    logic        crc_on    = 1'b0;
    logic        in_desc   = 1'b0;

    descriptor_tag_verifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // CRC-16/0x1021, MSB first, bit by bit
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    // Advances the predictor by one byte; returns 1 with the verdict when one is due.
    function automatic bit verify_byte(input t_in_item it, output t_out_item res);
        logic [7:0] b;
        bit         done;
        t_status    st;
        b    = it.data_byte;
        done = 1'b0;
        st   = ST_OK;
        res  = '0;
        if (it.start_of_descriptor) begin
            in_desc   = 1'b1;
            parse_pos = '0;
            tag_sum   = '0;
            tag_csum  = '0;
            tag_crc   = '0;
            crc_len   = '0;
            tag_loc   = '0;
            tag_ident = '0;
            want_loc  = it.expected_location;
            crc_on    = it.check_crc;
            body_crc  = seed;
        end
        if (in_desc) begin
            if (parse_pos < TAG_BYTES) begin
                if (parse_pos[3:0] != POS_CSUM) tag_sum = tag_sum + b;
                case (parse_pos[3:0])
                    POS_ID_LO:  tag_ident[7:0]  = b;
                    POS_ID_HI:  tag_ident[15:8] = b;
                    POS_CSUM:   tag_csum        = b;
                    POS_CRC_LO: tag_crc[7:0]    = b;
                    POS_CRC_HI: tag_crc[15:8]   = b;
                    POS_LEN_LO: crc_len[7:0]    = b;
                    POS_LEN_HI: crc_len[15:8]   = b;
                    POS_LOC_0, POS_LOC_1, POS_LOC_2, POS_LOC_3:
                        tag_loc[8 * parse_pos[1:0] +: 8] = b;
                    default: ;
                endcase
                parse_pos = parse_pos + 1'b1;
                if (parse_pos == TAG_BYTES) begin
                    // first failing check wins
                    done = 1'b1;
                    if (tag_loc != want_loc)      st = ST_LOC_ERR;
                    else if (tag_sum != tag_csum) st = ST_CSUM_ERR;
                    else if (!crc_on)             st = ST_OK;
                    else if (crc_len == 0)        st = (body_crc == tag_crc) ? ST_OK : ST_CRC_ERR;
                    else                          done = 1'b0;
                end
            end else begin
                body_crc  = crc_step(body_crc, b);
                parse_pos = parse_pos + 1'b1;
                if (parse_pos >= TAG_BYTES + crc_len) begin
                    done = 1'b1;
                    st   = (body_crc == tag_crc) ? ST_OK : ST_CRC_ERR;
                end
            end
        end
        if (done) begin
            res.status         = st;
            res.computed_crc   = body_crc;
            res.tag_identifier = tag_ident;
            in_desc            = 1'b0;
        end
        return done;
    endfunction

    function automatic t_desc desc_row(input logic [15:0] ident, input logic [31:0] loc,
                                       input logic [31:0] want, input logic sum_bad,
                                       input logic crc_en, input logic [15:0] len,
                                       input logic crc_ok, input logic [15:0] crc_field,
                                       input int cut, input int tail, input logic seed_mid,
                                       input logic typed, input t_status st,
                                       input logic [15:0] crc);
        t_desc d;
        d.ident     = ident;
        d.loc       = loc;
        d.want      = want;
        d.sum_bad   = sum_bad;
        d.crc_on    = crc_en;
        d.len       = len;
        d.crc_ok    = crc_ok;
        d.crc_field = crc_field;
        d.cut       = cut;
        d.tail      = tail;
        d.seed_mid  = seed_mid;
        d.typed     = typed;
        d.st        = st;
        d.crc       = crc;
        return d;
    endfunction

    // Offers one byte, holds it until taken, then updates the predictor.
    task automatic send_byte(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        while (!calm && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (verify_byte(it, res)) verdicts.push_back(typed ? typed_res : res);
    endtask

    // Seed writes only once the block has nothing left to report.
    task automatic write_seed(input logic [15:0] v);
        in_valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed = v;
    endtask

    task automatic send_stray(input int n);
        t_in_item it;
        repeat (n) begin
            it.start_of_descriptor = 1'b0;
            it.data_byte           = 8'($urandom);
            it.expected_location   = $urandom;
            it.check_crc           = 1'($urandom);
            send_byte(it, 1'b0, '0);
        end
    endtask

    task automatic send_desc(input t_desc d);
        logic [7:0]  tag [16];
        logic [7:0]  body [$];
        logic [15:0] crc_val;
        logic [7:0]  sum;
        t_in_item    it;
        t_out_item   typed_res;
        int          total;
        body = {};
        for (int i = 0; i < d.len; i++) body.push_back(8'($urandom));
        crc_val = d.crc_field;
        if (d.crc_ok) begin
            // the seed in force at the start byte is the one latched
            crc_val = seed;
            foreach (body[i]) crc_val = crc_step(crc_val, body[i]);
        end
        for (int i = 0; i < 16; i++) tag[i] = 8'($urandom);
        tag[POS_ID_LO]  = d.ident[7:0];
        tag[POS_ID_HI]  = d.ident[15:8];
        tag[POS_CRC_LO] = crc_val[7:0];
        tag[POS_CRC_HI] = crc_val[15:8];
        tag[POS_LEN_LO] = d.len[7:0];
        tag[POS_LEN_HI] = d.len[15:8];
        tag[POS_LOC_0]  = d.loc[7:0];
        tag[POS_LOC_1]  = d.loc[15:8];
        tag[POS_LOC_2]  = d.loc[23:16];
        tag[POS_LOC_3]  = d.loc[31:24];
        sum = '0;
        for (int i = 0; i < 16; i++) if (i != POS_CSUM) sum = sum + tag[i];
        tag[POS_CSUM] = d.sum_bad ? sum + 8'($urandom_range(255, 1)) : sum;

        typed_res.status         = d.st;
        typed_res.computed_crc   = d.crc;
        typed_res.tag_identifier = d.ident;

        total = TAG_BYTES + d.len;
        if (d.cut > 0 && d.cut < total) total = d.cut;
        for (int i = 0; i < total; i++) begin
            if (d.seed_mid && i == TAG_BYTES + d.len / 2) write_seed(~seed);
            it.start_of_descriptor = (i == 0);
            if (i < TAG_BYTES) it.data_byte = tag[i];
            else               it.data_byte = body[i - TAG_BYTES];
            // location and CRC enable only count on the start byte
            it.expected_location = (i == 0) ? d.want : $urandom;
            it.check_crc         = (i == 0) ? d.crc_on : 1'($urandom);
            send_byte(it, d.typed, typed_res);
        end
        send_stray(d.tail);
    endtask

    task automatic check_verdict(input t_out_item got);
        t_out_item want;
        if (verdicts.size() == 0) begin
            $error("result with none expected: status %0d crc %h id %h",
                   got.status, got.computed_crc, got.tag_identifier);
            fails++;
        end else begin
            want = verdicts.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.computed_crc !== want.computed_crc) begin
                $error("computed_crc: expected %h, got %h", want.computed_crc, got.computed_crc);
                fails++;
            end
            if (got.tag_identifier !== want.tag_identifier) begin
                $error("tag_identifier: expected %h, got %h",
                       want.tag_identifier, got.tag_identifier);
                fails++;
            end
        end
    endtask

    // Result side: check each item taken, then pick next cycle's stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) check_verdict(out_item);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 22);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        @(posedge clk);
        while (quiet_cycles < STUCK_LIMIT) @(posedge clk);
        $display("descriptor_tag_verifier: mismatch");
        $finish;
    end

    initial begin
        t_desc d;
        int    roll;
        int    stop_at;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes straight after reset are dropped
        send_stray(3);

        // seed is zero here, so early error verdicts carry crc 0000
        //                ident     loc            want           sb on len     ok crc_f   cut tl sm ty
        plan.push_back(desc_row(16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 16'd0,  0, 16'h0000,
                                0, 3, 0, 1, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 16'd0,  0, 16'hFFFF,
                                0, 0, 0, 1, ST_OK, 16'h0000));
        // location and checksum both wrong: location reported, body bytes ignored
        plan.push_back(desc_row(16'h0101, 32'h1234_5678, 32'h1234_5679, 1, 1, 16'd4,  1, 16'h0000,
                                0, 0, 0, 1, ST_LOC_ERR, 16'h0000));
        plan.push_back(desc_row(16'h0002, 32'h0000_0100, 32'h0000_0100, 1, 1, 16'd4,  1, 16'h0000,
                                0, 0, 0, 1, ST_CSUM_ERR, 16'h0000));
        // zero CRC length: seed compared with tag CRC
        plan.push_back(desc_row(16'h0003, 32'hA5A5_5A5A, 32'hA5A5_5A5A, 0, 1, 16'd0,  0, 16'h0000,
                                0, 0, 0, 1, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'h0004, 32'h8000_0001, 32'h8000_0001, 0, 1, 16'd0,  0, 16'hBEEF,
                                0, 0, 0, 1, ST_CRC_ERR, 16'h0000));
        plan.push_back(desc_row(16'h0005, 32'h0000_0007, 32'h0000_0007, 0, 1, 16'd1,  1, 16'h0000,
                                0, 0, 0, 0, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'h0006, 32'h0000_FFFF, 32'h0000_FFFF, 0, 1, 16'd20, 0, 16'h1D0F,
                                0, 0, 0, 0, ST_OK, 16'h0000));
        // restarts: one inside the tag, one inside the body
        plan.push_back(desc_row(16'h0007, 32'h0000_0009, 32'h0000_0009, 0, 1, 16'd8,  1, 16'h0000,
                                10, 0, 0, 0, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'h0008, 32'h0000_000A, 32'h0000_000A, 0, 1, 16'd5,  1, 16'h0000,
                                18, 0, 0, 0, ST_OK, 16'h0000));
        // seed rewritten mid-body: old seed stays latched for this descriptor
        plan.push_back(desc_row(16'h0009, 32'h0000_000B, 32'h0000_000B, 0, 1, 16'd64, 1, 16'h0000,
                                0, 0, 1, 0, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'h000A, 32'h0000_000C, 32'h0000_000C, 0, 1, 16'd3,  1, 16'h0000,
                                0, 2, 0, 0, ST_OK, 16'h0000));
        // CRC off: verdict at tag end, body bytes ignored
        plan.push_back(desc_row(16'h000B, 32'h0000_000D, 32'h0000_000D, 0, 0, 16'd10, 1, 16'h0000,
                                0, 0, 0, 0, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'h000C, 32'h0000_000E, 32'h0000_000E, 0, 1, 16'd0,  0, 16'hFFFF,
                                0, 0, 0, 0, ST_OK, 16'h0000));
        plan.push_back(desc_row(16'h000D, 32'h0000_000F, 32'h0000_000F, 0, 1, 16'h0101, 1, 16'h0000,
                                0, 0, 0, 0, ST_OK, 16'h0000));
        foreach (plan[i]) send_desc(plan[i]);

        // random descriptors in phases, each with its own seed
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       write_seed(16'h0000);
                1:       write_seed(16'hFFFF);
                default: write_seed(16'($urandom));
            endcase
            calm <= (ph == 2);
            if (ph == 1) hold_req <= 1'b1;
            stop_at = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop_at) begin
                d           = '0;
                d.ident     = 16'($urandom);
                d.want      = $urandom;
                d.loc       = ($urandom_range(99) < 88) ? d.want : $urandom;
                d.sum_bad   = ($urandom_range(99) < 10);
                d.crc_on    = ($urandom_range(99) < 75);
                roll        = $urandom_range(99);
                if (roll < 15)      d.len = 16'd0;
                else if (roll < 90) d.len = 16'($urandom_range(16, 1));
                else                d.len = 16'($urandom_range(80, 17));
                d.crc_ok    = ($urandom_range(99) < 75);
                d.crc_field = 16'($urandom);
                d.cut       = ($urandom_range(99) < 8) ? $urandom_range(TAG_BYTES + d.len - 1, 1)
                                                       : 0;
                d.tail      = ($urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
                send_desc(d);
            end
        end

        in_valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (fails == 0) begin
            $display("descriptor_tag_verifier: match");
        end else begin
            $display("descriptor_tag_verifier: mismatch");
        end
        $finish;
    end

endmodule
